// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in a cycle, consequent must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cdfc_pkg.sv =====
// types, constants and helpers of the dual channel fade controller
package cdfc_pkg;

   localparam int RATIO_BITS_DEF = 16;

   // register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_CT_MIN     = 3'd0;
   localparam logic [2:0] REG_CT_MAX     = 3'd1;
   localparam logic [2:0] REG_FADE_ON    = 3'd2;
   localparam logic [2:0] REG_FADE_OFF   = 3'd3;
   localparam logic [2:0] REG_FADE_LEVEL = 3'd4;
   localparam logic [2:0] REG_FADE_CT    = 3'd5;
   localparam logic [2:0] REG_PWM_TOP    = 3'd6;

   localparam logic [15:0] CT_MIN_RST     = 16'd153;
   localparam logic [15:0] CT_MAX_RST     = 16'd500;
   localparam logic [15:0] FADE_ON_RST    = 16'd50;
   localparam logic [15:0] FADE_OFF_RST   = 16'd40;
   localparam logic [15:0] FADE_LEVEL_RST = 16'd35;
   localparam logic [15:0] FADE_CT_RST    = 16'd60;
   localparam logic [15:0] PWM_TOP_RST    = 16'd65535;

   localparam logic [15:0] DEFAULT_MIREDS = 16'd370;
   localparam logic [7:0]  LEVEL_FULL     = 8'd254;
   localparam logic [7:0]  LEVEL_LOW      = 8'd1;
   localparam int          PCT_SPAN       = 99;
   localparam int          LEVEL_SPAN     = 253;
   localparam int          PCT_FULL       = 100;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_ONOFF = 2'd1,
      MODE_LEVEL = 2'd2,
      MODE_CT    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ONOFF = 2'd0,
      KIND_LEVEL = 2'd1,
      KIND_CT    = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_WB   = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // micro operations, each one multiply then one divide
   typedef enum logic [3:0] {
      OP_L2P = 4'd0,
      OP_RFM = 4'd1,
      OP_RFD = 4'd2,
      OP_ST  = 4'd3,
      OP_T2  = 4'd4,
      OP_SM  = 4'd5,
      OP_LB  = 4'd6,
      OP_LR  = 4'd7,
      OP_W   = 4'd8,
      OP_CC  = 4'd9,
      OP_WC  = 4'd10
   } op_type;

   function automatic logic [15:0] clamp_mireds(input logic [15:0] v,
                                                input logic [15:0] lo,
                                                input logic [15:0] hi);
      logic [15:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/cct_dual_channel_fade_controller.sv =====
// top level of the dual channel colour temperature fade controller
`include "assert_macros.svh"

// Cool/warm light fade controller. Items on the req_ channel are ticks,
// on/off, level or colour temperature events; each tick during a fade and
// each event that starts or settles a fade, but for a colour event during
// a colour fade, gives one rsp_ item with both duty percents, their timer
// compare values and the fade flag. All the arithmetic runs through one
// shared unit: a multiplier into a register, then a restoring divider
// retiring one quotient bit a cycle. A tick in the middle of a fade needs
// eight passes of that unit (the step ratio, its square, smoothstep, two
// interpolations, the warm split and two compare values); the last tick of
// a fade needs three; an event needs three passes to work out the targets
// and three more when it shows a frame. A tick with no fade running is
// dropped. req_ready is low while an item is being worked on; a finished
// item waits in the output register and the next input item is still taken
// meanwhile. Configuration is over an apb style port, one 16 bit register
// per word, and is meant to be written only while the block is idle.
module cct_dual_channel_fade_controller
   import cdfc_pkg::*;
#(
   parameter int RATIO_BITS = RATIO_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic                  req_on_request,
   input  logic [7:0]            req_level_value,
   input  logic [15:0]           req_mireds_value,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_cool_duty,
   output logic [6:0]            rsp_warm_duty,
   output logic [15:0]           rsp_cool_compare,
   output logic [15:0]           rsp_warm_compare,
   output logic                  rsp_fade_running,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // ratio width, multiplier operand widths and numerator width
   localparam int RW    = RATIO_BITS;
   localparam int AW    = 16;
   localparam int BW    = RW + 2;
   localparam int NW    = AW + BW;
   localparam int CNT_W = $clog2(NW + 1);
   localparam logic [RW-1:0] R_ONE  = {RW{1'b1}};
   localparam logic [BW-1:0] R_ONE3 = BW'(3 * ((1 << RW) - 1));

   // configuration registers
   logic [15:0] ct_min_ff, ct_max_ff, fade_on_ff, fade_off_ff;
   logic [15:0] fade_level_ff, fade_ct_ff, pwm_top_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   // architectural state
   logic          light_on_ff, light_on_in;
   logic [7:0]    cur_level_ff, cur_level_in;
   logic [15:0]   cur_mireds_ff, cur_mireds_in;
   logic          last_known_ff, last_known_in;
   logic [7:0]    last_level_ff, last_level_in;
   logic [15:0]   last_mireds_ff, last_mireds_in;
   logic [6:0]    shown_cool_ff, shown_cool_in;
   logic [6:0]    shown_warm_ff, shown_warm_in;
   logic [6:0]    start_b_ff, start_b_in;
   logic [6:0]    target_b_ff, target_b_in;
   logic [RW-1:0] start_r_ff, start_r_in;
   logic [RW-1:0] target_r_ff, target_r_in;
   kind_type      fade_kind_ff, fade_kind_in;
   logic [15:0]   fade_step_ff, fade_step_in;
   logic [15:0]   fade_total_ff, fade_total_in;
   logic          fade_active_ff, fade_active_in;

   // sequencer and working registers
   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   kind_type      cmd_kind_ff, cmd_kind_in;
   logic          cmd_restart_ff, cmd_restart_in;
   logic [6:0]    tb_calc_ff, tb_calc_in;
   logic [RW-1:0] tr_calc_ff, tr_calc_in;
   logic [RW-1:0] t_ff, t_in;
   logic [RW-1:0] x_ff, x_in;
   logic [7:0]    frame_b_ff, frame_b_in;
   logic [RW-1:0] frame_r_ff, frame_r_in;
   logic [15:0]   cool_cmp_ff, cool_cmp_in;
   logic [15:0]   warm_cmp_ff, warm_cmp_in;

   // shared multiply and divide unit
   logic [NW-1:0]    quo_ff, quo_in;
   logic [15:0]      rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    mul_a;
   logic [BW-1:0]    mul_b;
   logic [15:0]      div_d;
   logic [NW-1:0]    mul_p;
   logic [16:0]      rem_sh;
   logic             rem_ge;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    rsp_cool_ff, rsp_cool_in;
   logic [6:0]    rsp_warm_ff, rsp_warm_in;
   logic [15:0]   rsp_ccmp_ff, rsp_ccmp_in;
   logic [15:0]   rsp_wcmp_ff, rsp_wcmp_in;
   logic          rsp_fade_ff, rsp_fade_in;

   // helpers
   logic [7:0]    duty_sum;
   logic [RW-1:0] rfd_v;
   logic [15:0]   fade_ticks;
   logic [15:0]   mir_off;
   logic [7:0]    cool_full;

   // ------------------------------------------------------------------
   // configuration port, writes land on the access phase
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_comb begin
      prdata = '0;
      case (csr_idx)
         REG_CT_MIN:     prdata = 32'(ct_min_ff);
         REG_CT_MAX:     prdata = 32'(ct_max_ff);
         REG_FADE_ON:    prdata = 32'(fade_on_ff);
         REG_FADE_OFF:   prdata = 32'(fade_off_ff);
         REG_FADE_LEVEL: prdata = 32'(fade_level_ff);
         REG_FADE_CT:    prdata = 32'(fade_ct_ff);
         REG_PWM_TOP:    prdata = 32'(pwm_top_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ct_min_ff     <= CT_MIN_RST;
         ct_max_ff     <= CT_MAX_RST;
         fade_on_ff    <= FADE_ON_RST;
         fade_off_ff   <= FADE_OFF_RST;
         fade_level_ff <= FADE_LEVEL_RST;
         fade_ct_ff    <= FADE_CT_RST;
         pwm_top_ff    <= PWM_TOP_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CT_MIN:     ct_min_ff     <= pwdata[15:0];
            REG_CT_MAX:     ct_max_ff     <= pwdata[15:0];
            REG_FADE_ON:    fade_on_ff    <= pwdata[15:0];
            REG_FADE_OFF:   fade_off_ff   <= pwdata[15:0];
            REG_FADE_LEVEL: fade_level_ff <= pwdata[15:0];
            REG_FADE_CT:    fade_ct_ff    <= pwdata[15:0];
            REG_PWM_TOP:    pwm_top_ff    <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // operand selection for the shared unit
   // ------------------------------------------------------------------
   assign duty_sum = {1'b0, shown_cool_ff} + {1'b0, shown_warm_ff};
   assign mir_off  = clamp_mireds(cur_mireds_ff, ct_min_ff, ct_max_ff) - ct_min_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_d = 16'd1;
      case (op_ff)
         OP_L2P: begin
            // level to percent, level zero is replaced at writeback
            mul_a = AW'(cur_level_ff - 8'd1);
            mul_b = BW'(PCT_SPAN);
            div_d = 16'(LEVEL_SPAN);
         end
         OP_RFM: begin
            mul_a = mir_off;
            mul_b = BW'(R_ONE);
            div_d = ct_max_ff - ct_min_ff;
         end
         OP_RFD: begin
            mul_a = AW'(shown_warm_ff);
            mul_b = BW'(R_ONE);
            div_d = 16'(duty_sum);
         end
         OP_ST: begin
            mul_a = fade_step_ff;
            mul_b = BW'(R_ONE);
            div_d = fade_total_ff;
         end
         OP_T2: begin
            mul_a = AW'(t_ff);
            mul_b = BW'(t_ff);
            div_d = 16'(R_ONE);
         end
         OP_SM: begin
            // t squared times (3 - 2t), all scaled by the ratio unit
            mul_a = AW'(x_ff);
            mul_b = R_ONE3 - BW'({t_ff, 1'b0});
            div_d = 16'(R_ONE);
         end
         OP_LB: begin
            mul_a = (target_b_ff >= start_b_ff) ? AW'(target_b_ff - start_b_ff)
                                                : AW'(start_b_ff - target_b_ff);
            mul_b = BW'(x_ff);
            div_d = 16'(R_ONE);
         end
         OP_LR: begin
            mul_a = (target_r_ff >= start_r_ff) ? AW'(target_r_ff - start_r_ff)
                                                : AW'(start_r_ff - target_r_ff);
            mul_b = BW'(x_ff);
            div_d = 16'(R_ONE);
         end
         OP_W: begin
            mul_a = AW'(frame_b_ff);
            mul_b = BW'(frame_r_ff);
            div_d = 16'(R_ONE);
         end
         OP_CC: begin
            mul_a = pwm_top_ff;
            mul_b = BW'(shown_cool_ff);
            div_d = 16'(PCT_FULL);
         end
         OP_WC: begin
            mul_a = pwm_top_ff;
            mul_b = BW'(shown_warm_ff);
            div_d = 16'(PCT_FULL);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
            div_d = 16'd1;
         end
      endcase
   end

   assign mul_p  = NW'(mul_a) * NW'(mul_b);
   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign rem_ge = rem_sh >= {1'b0, div_d};

   // ratio of the shown duties, zero when nothing is lit
   assign rfd_v = (duty_sum == 8'd0) ? '0 : quo_ff[RW-1:0];

   always_comb begin
      case (cmd_kind_ff)
         KIND_ONOFF: fade_ticks = light_on_ff ? fade_on_ff : fade_off_ff;
         KIND_CT:    fade_ticks = fade_ct_ff;
         default:    fade_ticks = fade_level_ff;
      endcase
   end

   assign cool_full = frame_b_ff - quo_ff[7:0];

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      light_on_in    = light_on_ff;
      cur_level_in   = cur_level_ff;
      cur_mireds_in  = cur_mireds_ff;
      last_known_in  = last_known_ff;
      last_level_in  = last_level_ff;
      last_mireds_in = last_mireds_ff;
      shown_cool_in  = shown_cool_ff;
      shown_warm_in  = shown_warm_ff;
      start_b_in     = start_b_ff;
      target_b_in    = target_b_ff;
      start_r_in     = start_r_ff;
      target_r_in    = target_r_ff;
      fade_kind_in   = fade_kind_ff;
      fade_step_in   = fade_step_ff;
      fade_total_in  = fade_total_ff;
      fade_active_in = fade_active_ff;
      state_in       = state_ff;
      op_in          = op_ff;
      cmd_kind_in    = cmd_kind_ff;
      cmd_restart_in = cmd_restart_ff;
      tb_calc_in     = tb_calc_ff;
      tr_calc_in     = tr_calc_ff;
      t_in           = t_ff;
      x_in           = x_ff;
      frame_b_in     = frame_b_ff;
      frame_r_in     = frame_r_ff;
      cool_cmp_in    = cool_cmp_ff;
      warm_cmp_in    = warm_cmp_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_cool_in    = rsp_cool_ff;
      rsp_warm_in    = rsp_warm_ff;
      rsp_ccmp_in    = rsp_ccmp_ff;
      rsp_wcmp_in    = rsp_wcmp_ff;
      rsp_fade_in    = rsp_fade_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (mode_type'(req_mode))
                  MODE_TICK: begin
                     // a tick with no fade running is simply dropped
                     if (fade_active_ff) begin
                        fade_step_in = fade_step_ff + 16'd1;
                        state_in     = ST_MUL;
                        if (fade_step_in >= fade_total_ff) begin
                           fade_active_in = 1'b0;
                           frame_b_in     = {1'b0, target_b_ff};
                           frame_r_in     = target_r_ff;
                           op_in          = OP_W;
                        end else begin
                           op_in = OP_ST;
                        end
                     end
                  end
                  MODE_ONOFF: begin
                     // remember the lit look when switching off, bring it back on
                     if (!req_on_request && light_on_ff) begin
                        last_known_in  = 1'b1;
                        last_level_in  = cur_level_ff;
                        last_mireds_in = cur_mireds_ff;
                     end
                     if (req_on_request && !light_on_ff && last_known_ff) begin
                        cur_level_in  = last_level_ff;
                        cur_mireds_in = last_mireds_ff;
                     end
                     light_on_in = req_on_request;
                     if (req_on_request && cur_level_in <= LEVEL_LOW) begin
                        cur_level_in = LEVEL_FULL;
                        if (last_known_in) begin
                           last_level_in = LEVEL_FULL;
                        end
                     end
                     cmd_kind_in    = KIND_ONOFF;
                     cmd_restart_in = 1'b1;
                     op_in          = OP_L2P;
                     state_in       = ST_MUL;
                  end
                  MODE_LEVEL: begin
                     cur_level_in = req_level_value;
                     if (light_on_ff) begin
                        last_known_in  = 1'b1;
                        last_level_in  = req_level_value;
                        cmd_kind_in    = KIND_LEVEL;
                        cmd_restart_in = 1'b1;
                        op_in          = OP_L2P;
                        state_in       = ST_MUL;
                     end
                  end
                  MODE_CT: begin
                     cur_mireds_in = clamp_mireds(req_mireds_value, ct_min_ff, ct_max_ff);
                     if (light_on_ff) begin
                        last_known_in  = 1'b1;
                        last_level_in  = cur_level_ff;
                        last_mireds_in = cur_mireds_in;
                        cmd_kind_in    = KIND_CT;
                        cmd_restart_in = 1'b0;
                        op_in          = OP_L2P;
                        state_in       = ST_MUL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_MUL: begin
            quo_in   = mul_p;
            rem_in   = '0;
            cnt_in   = CNT_W'(NW);
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in = rem_ge ? 16'(rem_sh - {1'b0, div_d}) : rem_sh[15:0];
            quo_in = {quo_ff[NW-2:0], rem_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_WB;
            end
         end

         ST_WB: begin
            state_in = ST_MUL;
            case (op_ff)
               OP_L2P: begin
                  tb_calc_in = (light_on_ff && cur_level_ff != 8'd0) ?
                               (quo_ff[6:0] + 7'd1) : 7'd0;
                  op_in = OP_RFM;
               end
               OP_RFM: begin
                  // empty or inverted range sits half way
                  tr_calc_in = (ct_max_ff <= ct_min_ff) ? (R_ONE >> 1) : quo_ff[RW-1:0];
                  op_in = OP_RFD;
               end
               OP_RFD: begin
                  if (cmd_kind_ff == KIND_CT && fade_active_ff &&
                      fade_kind_ff == KIND_CT && !cmd_restart_ff) begin
                     // colour change during a colour fade moves the target, and ends the fade if already there
                     target_b_in = tb_calc_ff;
                     target_r_in = tr_calc_ff;
                     if (duty_sum == {1'b0, tb_calc_ff} && rfd_v == tr_calc_ff) begin
                        fade_active_in = 1'b0;
                     end
                     state_in = ST_IDLE;
                  end else begin
                     start_b_in   = duty_sum[6:0];
                     start_r_in   = (duty_sum != 8'd0) ? rfd_v : tr_calc_ff;
                     target_b_in  = tb_calc_ff;
                     target_r_in  = tr_calc_ff;
                     fade_kind_in = cmd_kind_ff;
                     if (start_b_in == tb_calc_ff && start_r_in == tr_calc_ff) begin
                        // already there, show the target and stop
                        fade_active_in = 1'b0;
                        frame_b_in     = {1'b0, tb_calc_ff};
                        frame_r_in     = tr_calc_ff;
                        op_in          = OP_W;
                     end else if (cmd_restart_ff || !fade_active_ff) begin
                        // new fade, first frame is the start point
                        fade_step_in   = '0;
                        fade_total_in  = (fade_ticks == 16'd0) ? 16'd1 : fade_ticks;
                        fade_active_in = 1'b1;
                        frame_b_in     = {1'b0, start_b_in};
                        frame_r_in     = start_r_in;
                        op_in          = OP_W;
                     end else begin
                        // fade kind turns to colour, step count runs on
                        state_in = ST_IDLE;
                     end
                  end
               end
               OP_ST: begin
                  t_in  = quo_ff[RW-1:0];
                  op_in = OP_T2;
               end
               OP_T2: begin
                  x_in  = quo_ff[RW-1:0];
                  op_in = OP_SM;
               end
               OP_SM: begin
                  x_in  = quo_ff[RW-1:0];
                  op_in = OP_LB;
               end
               OP_LB: begin
                  frame_b_in = (target_b_ff >= start_b_ff) ?
                               ({1'b0, start_b_ff} + quo_ff[7:0]) :
                               ({1'b0, start_b_ff} - quo_ff[7:0]);
                  op_in = OP_LR;
               end
               OP_LR: begin
                  frame_r_in = (target_r_ff >= start_r_ff) ?
                               (start_r_ff + quo_ff[RW-1:0]) :
                               (start_r_ff - quo_ff[RW-1:0]);
                  op_in = OP_W;
               end
               OP_W: begin
                  // split brightness into warm and cool parts
                  if (frame_b_ff == 8'd0) begin
                     shown_cool_in = '0;
                     shown_warm_in = '0;
                  end else begin
                     shown_warm_in = quo_ff[6:0];
                     shown_cool_in = cool_full[6:0];
                  end
                  op_in = OP_CC;
               end
               OP_CC: begin
                  cool_cmp_in = quo_ff[15:0];
                  op_in       = OP_WC;
               end
               OP_WC: begin
                  warm_cmp_in = quo_ff[15:0];
                  state_in    = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cool_in  = shown_cool_ff;
               rsp_warm_in  = shown_warm_ff;
               rsp_ccmp_in  = cool_cmp_ff;
               rsp_wcmp_in  = warm_cmp_ff;
               rsp_fade_in  = fade_active_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_on_ff    <= 1'b0;
         cur_level_ff   <= LEVEL_FULL;
         cur_mireds_ff  <= DEFAULT_MIREDS;
         last_known_ff  <= 1'b0;
         last_level_ff  <= LEVEL_FULL;
         last_mireds_ff <= DEFAULT_MIREDS;
         shown_cool_ff  <= '0;
         shown_warm_ff  <= '0;
         start_b_ff     <= '0;
         target_b_ff    <= '0;
         start_r_ff     <= '0;
         target_r_ff    <= '0;
         fade_kind_ff   <= KIND_ONOFF;
         fade_step_ff   <= '0;
         fade_total_ff  <= '0;
         fade_active_ff <= 1'b0;
         state_ff       <= ST_IDLE;
         op_ff          <= OP_L2P;
         cmd_kind_ff    <= KIND_ONOFF;
         cmd_restart_ff <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         light_on_ff    <= light_on_in;
         cur_level_ff   <= cur_level_in;
         cur_mireds_ff  <= cur_mireds_in;
         last_known_ff  <= last_known_in;
         last_level_ff  <= last_level_in;
         last_mireds_ff <= last_mireds_in;
         shown_cool_ff  <= shown_cool_in;
         shown_warm_ff  <= shown_warm_in;
         start_b_ff     <= start_b_in;
         target_b_ff    <= target_b_in;
         start_r_ff     <= start_r_in;
         target_r_ff    <= target_r_in;
         fade_kind_ff   <= fade_kind_in;
         fade_step_ff   <= fade_step_in;
         fade_total_ff  <= fade_total_in;
         fade_active_ff <= fade_active_in;
         state_ff       <= state_in;
         op_ff          <= op_in;
         cmd_kind_ff    <= cmd_kind_in;
         cmd_restart_ff <= cmd_restart_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      tb_calc_ff  <= tb_calc_in;
      tr_calc_ff  <= tr_calc_in;
      t_ff        <= t_in;
      x_ff        <= x_in;
      frame_b_ff  <= frame_b_in;
      frame_r_ff  <= frame_r_in;
      cool_cmp_ff <= cool_cmp_in;
      warm_cmp_ff <= warm_cmp_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_cool_ff <= rsp_cool_in;
      rsp_warm_ff <= rsp_warm_in;
      rsp_ccmp_ff <= rsp_ccmp_in;
      rsp_wcmp_ff <= rsp_wcmp_in;
      rsp_fade_ff <= rsp_fade_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cool_duty    = rsp_cool_ff;
   assign rsp_warm_duty    = rsp_warm_ff;
   assign rsp_cool_compare = rsp_ccmp_ff;
   assign rsp_warm_compare = rsp_wcmp_ff;
   assign rsp_fade_running = rsp_fade_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `ASSERT_SAME(a_div_count, clock, reset, state_ff == ST_DIV, cnt_ff != '0,
                "divider running with an empty bit count")
   `ASSERT_SAME(a_fade_total, clock, reset, fade_active_ff, fade_total_ff != 16'd0,
                "fade running with zero length")
   `ASSERT_NEXT(a_mul_to_div, clock, reset, state_ff == ST_MUL,
                state_ff == ST_DIV && cnt_ff == CNT_W'(NW),
                "multiply not followed by a full division")

endmodule
